@@ rtl/core/assert_macros.svh @@
// Shared assertion helpers, clocked on aclk and held off while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AST_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication
`define AST_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ rtl/core/prqs_pkg.sv @@
package prqs_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int LEAF_N   = 1 << IDX_W;
    localparam int WAIT_W   = $clog2(IDX_W + 1);
    localparam int KEY_W    = 10;
    localparam int OCC_W    = 7;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    localparam logic [1:0] STAT_INSERTED = 2'd0;
    localparam logic [1:0] STAT_REMOVED  = 2'd1;
    localparam logic [1:0] STAT_FULL     = 2'd2;
    localparam logic [1:0] STAT_EMPTY    = 2'd3;

    typedef enum logic [1:0] {
        MODE_FCFS,
        MODE_COST,
        MODE_PRIO,
        MODE_RSVD
    } mode_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_SEARCH,
        FSM_EMIT
    } fsm_t;

    typedef struct packed {
        logic        command;
        logic [15:0] job_tag;
        logic [9:0]  job_cost;
        logic [7:0]  job_priority;
    } in_item_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [15:0]      out_tag;
        logic [9:0]       out_cost;
        logic [7:0]       out_priority;
        logic [OCC_W-1:0] occupancy;
    } out_item_t;

    typedef struct packed {
        logic [15:0] tag;
        logic [9:0]  cost;
        logic [7:0]  prio;
    } job_t;

    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctrl_t;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [IDX_W-1:0] idx;
        job_t             job;
    } node_t;

    // smaller key wins; unused policy code behaves as first come
    function automatic logic [KEY_W-1:0] leaf_key(input mode_t mode, input job_t job);
        logic [KEY_W-1:0] key;
        key = '0;
        case (mode)
            MODE_COST: key = job.cost;
            MODE_PRIO: key = KEY_W'(~job.prio);
            default:   key = '0;
        endcase
        return key;
    endfunction

    // a always holds the older entries, so it wins ties
    function automatic node_t node_merge(input node_t a, input node_t b);
        node_t res;
        if (a.valid && (!b.valid || a.key <= b.key)) begin
            res = a;
        end else begin
            res = b;
        end
        return res;
    endfunction

endpackage

@@ rtl/core/policy_ready_queue_select_top.sv @@
// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  s_item (in_item_t)
// m_        out        m_valid / m_ready  m_item (out_item_t)
// cfg_      in         cfg_wr_en          cfg_wr_data (policy mode)
//
// Insert, full reject and empty remove: result goes via res_reg and m_item_reg to m_.
// Remove: the search state waits until the registered selection tree, one register per
// level, has settled on the pick, which then goes out through the same registers.
// One item in flight; s_ready is high only while idle. A result still waiting on m_ holds
// the next item in its emit state, so a long m_ stall blocks acceptance.
// Synchronous active-low reset empties the queue and sets first-come policy.

`include "assert_macros.svh"

module policy_ready_queue_select_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  prqs_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output prqs_pkg::out_item_t m_item,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_wr_data
);
    import prqs_pkg::*;

    mode_t            mode_reg;
    fsm_t             state_reg, state_next;
    logic [WAIT_W-1:0] wait_reg, wait_next;
    logic [CNT_W-1:0] count_reg, count_next;
    out_item_t        res_reg, res_next;
    out_item_t        m_item_reg, m_item_next;
    logic             m_valid_reg, m_valid_next;

    logic  accept;
    logic  ins_go;
    logic  rem_go;
    logic  has_room;
    job_t  in_job;
    node_t root;

    job_t       cell_job   [CAPACITY];
    logic       cell_valid [CAPACITY];
    job_t       nb_job     [CAPACITY];
    logic       nb_valid   [CAPACITY];
    cell_ctrl_t cell_ctrl  [CAPACITY];

    assign s_ready  = (state_reg == FSM_IDLE);
    assign accept   = s_valid && s_ready;
    assign has_room = (count_reg < CNT_W'(CAPACITY));
    assign ins_go   = accept && (s_item.command == CMD_INSERT) && has_room;
    assign rem_go   = (state_reg == FSM_SEARCH) && (wait_reg == WAIT_W'(IDX_W));
    assign in_job   = '{tag: s_item.job_tag, cost: s_item.job_cost, prio: s_item.job_priority};

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++) begin : g_cell
            if (i == CAPACITY - 1) begin : g_last
                assign nb_job[i]   = '0;
                assign nb_valid[i] = 1'b0;
            end else begin : g_mid
                assign nb_job[i]   = cell_job[i+1];
                assign nb_valid[i] = cell_valid[i+1];
            end

            assign cell_ctrl[i].load  = ins_go && (count_reg == CNT_W'(i));
            assign cell_ctrl[i].shift = rem_go && (IDX_W'(i) >= root.idx);

            prqs_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .ctrl     (cell_ctrl[i]),
                .new_job  (in_job),
                .nb_job   (nb_job[i]),
                .nb_valid (nb_valid[i]),
                .job      (cell_job[i]),
                .valid    (cell_valid[i])
            );
        end
    endgenerate

    prqs_tree u_tree (
        .aclk   (aclk),
        .mode   (mode_reg),
        .jobs   (cell_job),
        .valids (cell_valid),
        .root   (root)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_FCFS;
        end else if (cfg_wr_en) begin
            mode_reg <= mode_t'(cfg_wr_data);
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            FSM_IDLE: begin
                if (accept) begin
                    if (s_item.command == CMD_REMOVE && count_reg != '0) begin
                        state_next = FSM_SEARCH;
                    end else begin
                        state_next = FSM_EMIT;
                    end
                end
            end
            FSM_SEARCH: begin
                if (rem_go) begin
                    state_next = FSM_EMIT;
                end
            end
            FSM_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = FSM_IDLE;
                end
            end
            default: state_next = FSM_IDLE;
        endcase
    end

    always_comb begin
        wait_next    = wait_reg;
        count_next   = count_reg;
        res_next     = res_reg;
        m_item_next  = m_item_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            FSM_IDLE: begin
                if (accept) begin
                    wait_next = '0;
                    res_next  = '0;
                    if (s_item.command == CMD_INSERT) begin
                        if (has_room) begin
                            count_next         = count_reg + 1'b1;
                            res_next.status    = STAT_INSERTED;
                            res_next.occupancy = OCC_W'(count_reg + 1'b1);
                        end else begin
                            res_next.status    = STAT_FULL;
                            res_next.occupancy = OCC_W'(count_reg);
                        end
                    end else begin
                        res_next.status    = STAT_EMPTY;
                        res_next.occupancy = OCC_W'(count_reg);
                    end
                end
            end
            FSM_SEARCH: begin
                if (rem_go) begin
                    count_next            = count_reg - 1'b1;
                    res_next.status       = STAT_REMOVED;
                    res_next.out_tag      = root.job.tag;
                    res_next.out_cost     = root.job.cost;
                    res_next.out_priority = root.job.prio;
                    res_next.occupancy    = OCC_W'(count_reg - 1'b1);
                end else begin
                    wait_next = wait_reg + 1'b1;
                end
            end
            FSM_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_item_next  = res_reg;
                    m_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= FSM_IDLE;
            wait_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            wait_reg    <= wait_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg    <= res_next;
        m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    `AST_IMPLIES(a_count_bound, 1'b1, count_reg <= CNT_W'(CAPACITY))
    `AST_IMPLIES(a_pick_valid, rem_go, root.valid && count_reg != '0)
    `AST_NEXT(a_busy_after_accept, accept, state_reg != FSM_IDLE)
    `AST_NEXT(a_insert_counts, ins_go, count_reg == CNT_W'($past(count_reg) + 1'b1))

endmodule

@@ rtl/core/prqs_cell.sv @@
module prqs_cell (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  prqs_pkg::cell_ctrl_t ctrl,
    input  prqs_pkg::job_t       new_job,
    input  prqs_pkg::job_t       nb_job,
    input  logic                 nb_valid,
    output prqs_pkg::job_t       job,
    output logic                 valid
);
    import prqs_pkg::*;

    job_t job_reg;
    logic valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ctrl.load) begin
            valid_reg <= 1'b1;
        end else if (ctrl.shift) begin
            valid_reg <= nb_valid;
        end
    end

    // younger neighbor moves down to close the gap
    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            job_reg <= new_job;
        end else if (ctrl.shift) begin
            job_reg <= nb_job;
        end
    end

    assign job   = job_reg;
    assign valid = valid_reg;

endmodule

@@ rtl/core/prqs_tree.sv @@
module prqs_tree (
    input  logic            aclk,
    input  prqs_pkg::mode_t mode,
    input  prqs_pkg::job_t  jobs [prqs_pkg::CAPACITY],
    input  logic            valids [prqs_pkg::CAPACITY],
    output prqs_pkg::node_t root
);
    import prqs_pkg::*;

    node_t leaf [LEAF_N];
    // heap order: node n has children 2n and 2n+1, one register level per tree level
    node_t heap_reg [1:LEAF_N-1];

    genvar l, n;
    generate
        for (l = 0; l < LEAF_N; l++) begin : g_leaf
            if (l < CAPACITY) begin : g_used
                assign leaf[l] = '{valid: valids[l], key: leaf_key(mode, jobs[l]),
                                   idx: IDX_W'(l), job: jobs[l]};
            end else begin : g_pad
                assign leaf[l] = '0;
            end
        end

        for (n = 1; n < LEAF_N; n++) begin : g_node
            if (2 * n >= LEAF_N) begin : g_bottom
                always_ff @(posedge aclk) begin
                    heap_reg[n] <= node_merge(leaf[2*n-LEAF_N], leaf[2*n+1-LEAF_N]);
                end
            end else begin : g_inner
                always_ff @(posedge aclk) begin
                    heap_reg[n] <= node_merge(heap_reg[2*n], heap_reg[2*n+1]);
                end
            end
        end
    endgenerate

    assign root = heap_reg[1];

endmodule
